### hw/rtl/cycle_count_to_time_keeper_core_macros.svh
// Assertion macros for the cycle-count time keeper checker.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef CYCLE_COUNT_TO_TIME_KEEPER_CORE_MACROS_SVH
`define CYCLE_COUNT_TO_TIME_KEEPER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCTTK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CCTTK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/ccttk_pkg.sv
// Shared types and constants for the cycle-count time keeper.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccttk_pkg;

    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned SUM_W      = 33;
    localparam int unsigned CPM_W      = 23;
    localparam int unsigned CPU_W      = 13;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US = 1'd1;

    localparam logic [CPM_W-1:0] CPM_RESET = 23'd100000;
    localparam logic [CPU_W-1:0] CPU_RESET = 13'd100;

    localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
    localparam logic [31:0] US_PER_MS     = 32'd1000;

    // Divide by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38;
    // exact for every 32-bit dividend.
    localparam int unsigned SEC_Q_W    = 23;
    localparam int unsigned SEC_PROD_W = 61;
    localparam int unsigned SEC_SHIFT  = 38;
    localparam logic [28:0] SEC_RECIP  = 29'h1062_4DD3;

    // Divider pass lengths for the two divisions of one sample.
    localparam logic [STEP_W-1:0] STEPS_MS  = 6'd33;
    localparam logic [STEP_W-1:0] STEPS_US  = 6'd23;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MS_START,
        ST_MS_WAIT,
        ST_SEC_QUOT,
        ST_SEC_CARRY,
        ST_US_START,
        ST_US_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [SUM_W-1:0]  dividend;
        logic [CPM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [CPM_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/cycle_count_to_time_keeper_core.sv
// Cycle-count time keeper: sequencer, time state and output register.
// Depends on ccttk_pkg and ccttk_div.
//
// s_tdata carries one sample of a free-running 32-bit cycle counter; each
// transfer yields one result on m_tdata: elapsed milliseconds, whole seconds
// and microseconds, all modulo 2^32. The first sample after reset only sets
// the baseline and its result shows the current state.
// cfg_wr_* writes clocks_per_ms (index 0) and clocks_per_us (index 1); write
// them only while no sample is in flight.
// Sequence: one shared bit-serial divider runs twice (33 then 23 quotient
// bits) and a reciprocal multiply carries whole seconds in the states
// ST_SEC_QUOT and ST_SEC_CARRY; the result then loads the output register
// and the sequencer returns to idle for the next sample. A baseline sample
// skips the first division; clocks_per_us of zero skips the last one.
// s_tready is high only while the sequencer is idle.
// Reset: aresetn (synchronous, active low) restores both registers to their
// defaults, clears the time state apart from the payload registers and drops m_tvalid.
// Stall: a finished result waits in the output register while the next
// sample is taken; that result holds in the sequencer until m_tready frees
// the register.
`default_nettype none

module cycle_count_to_time_keeper_core import ccttk_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,

    // Configuration write port.
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire [CPM_W-1:0]      cfg_wr_data,

    // Sample input. tdata: [31:0] counter_value
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [31:0]           s_tdata,

    // Result output. tdata: [31:0] ms_ticks, [63:32] seconds, [95:64] time_us
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [95:0]          m_tdata
);

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [CPM_W-1:0]    cpm_reg;
    logic [CPU_W-1:0]    cpu_reg;

    // Time state.
    logic                primed_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [CPM_W-1:0]    rem_reg;
    logic [31:0]         ms_reg;
    logic [31:0]         mark_reg;
    logic [31:0]         sec_reg;
    logic [31:0]         ms_us_reg;
    logic [CPM_W-1:0]    extra_reg;
    logic [SEC_Q_W-1:0]  sec_q_reg;

    // Output register.
    logic                m_valid_reg;
    logic [95:0]         m_data_reg;

    logic                in_xfer;
    logic                out_free;
    logic [SUM_W-1:0]    rem_sum;
    logic [CPM_W-1:0]    ms_divisor;
    logic [31:0]         elapsed;
    logic [SEC_PROD_W-1:0] sec_prod;
    logic [31:0]         sec_step;
    logic [31:0]         time_us;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Wrapped counter difference added to the leftover cycles; never leaves 33 bits.
    assign rem_sum    = {{(SUM_W-CPM_W){1'b0}}, rem_reg}
                      + {1'b0, sample_reg - prev_reg};
    // Treat a zero tick length as one cycle per millisecond.
    assign ms_divisor = (cpm_reg == '0) ? CPM_W'(1) : cpm_reg;
    assign elapsed    = ms_reg - mark_reg;
    // Whole seconds since the mark, by reciprocal multiply.
    assign sec_prod   = SEC_PROD_W'(elapsed) * SEC_PROD_W'(SEC_RECIP);
    // Milliseconds covered by those whole seconds; advance the mark by this.
    assign sec_step   = {{(32-SEC_Q_W){1'b0}}, sec_q_reg}
                      * {{(32-10){1'b0}}, MS_PER_SECOND};
    assign time_us    = ms_us_reg + {{(32-CPM_W){1'b0}}, extra_reg};

    ccttk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state, handshake and divider requests.
    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.steps    = STEPS_MS;
        div_req.dividend = rem_sum;
        div_req.divisor  = ms_divisor;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // Baseline sample adds nothing: go straight to the seconds carry.
                    state_next = primed_reg ? ST_MS_START : ST_SEC_QUOT;
                end
            end
            ST_MS_START: begin
                div_req.start = 1'b1;
                state_next    = ST_MS_WAIT;
            end
            ST_MS_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_SEC_QUOT;
                end
            end
            ST_SEC_QUOT: begin
                state_next = ST_SEC_CARRY;
            end
            ST_SEC_CARRY: begin
                state_next = ST_US_START;
            end
            ST_US_START: begin
                div_req.steps    = STEPS_US;
                div_req.dividend = {rem_reg, {(SUM_W-CPM_W){1'b0}}};
                div_req.divisor  = {{(CPM_W-CPU_W){1'b0}}, cpu_reg};
                if (cpu_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_US_WAIT;
                end
            end
            ST_US_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; unknown indexes cannot occur with a one-bit index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpm_reg <= CPM_RESET;
            cpu_reg <= CPU_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_CLOCKS_PER_MS: cpm_reg <= cfg_wr_data;
                REG_CLOCKS_PER_US: cpu_reg <= cfg_wr_data[CPU_W-1:0];
                default: ;
            endcase
        end
    end

    // Time state updates, one per sequencer step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            prev_reg   <= '0;
            rem_reg    <= '0;
            ms_reg     <= '0;
            mark_reg   <= '0;
            sec_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && !primed_reg) begin
                        primed_reg <= 1'b1;
                        prev_reg   <= s_tdata;
                    end
                end
                ST_MS_START: begin
                    prev_reg <= sample_reg;
                end
                ST_MS_WAIT: begin
                    if (div_rsp.done) begin
                        ms_reg  <= ms_reg + div_rsp.quotient[31:0];
                        rem_reg <= div_rsp.remainder;
                    end
                end
                ST_SEC_CARRY: begin
                    // Advance the mark by whole seconds only; leftover ms stay pending.
                    mark_reg <= mark_reg + sec_step;
                    sec_reg  <= sec_reg + {{(32-SEC_Q_W){1'b0}}, sec_q_reg};
                end
                default: ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= s_tdata;
        end
        if (state_reg == ST_SEC_QUOT) begin
            sec_q_reg <= sec_prod[SEC_PROD_W-1:SEC_SHIFT];
        end
        if (state_reg == ST_US_START) begin
            ms_us_reg <= ms_reg * US_PER_MS;
            extra_reg <= '0;
        end
        if (state_reg == ST_US_WAIT && div_rsp.done) begin
            extra_reg <= div_rsp.quotient[CPM_W-1:0];
        end
    end

    // Output register: load a finished result, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {time_us, sec_reg, ms_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### hw/rtl/ccttk_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ccttk_pkg for the request and response structs.
`default_nettype none

module ccttk_div import ccttk_pkg::*; (
    input  wire      aclk,
    input  wire      aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] count_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [CPM_W-1:0]  part_reg;
    logic [CPM_W-1:0]  divisor_reg;

    logic [CPM_W:0]    trial;
    logic [CPM_W:0]    trial_diff;
    logic              fits;

    // Shift in the next dividend bit and try one subtraction.
    always_comb begin
        trial      = {part_reg, acc_reg[SUM_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = (trial >= {1'b0, divisor_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= req.steps;
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg     <= req.dividend;
            part_reg    <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            acc_reg  <= {acc_reg[SUM_W-2:0], fits};
            part_reg <= fits ? trial_diff[CPM_W-1:0] : trial[CPM_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = acc_reg;
    assign rsp.remainder = part_reg;

endmodule

`default_nettype wire

### hw/rtl/ccttk_checker.sv
// Port-level checker for the cycle-count time keeper, bound to the top level.
// Depends on ccttk_pkg and the assertion macro header.
`default_nettype none
`include "cycle_count_to_time_keeper_core_macros.svh"

module ccttk_checker import ccttk_pkg::*; (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [95:0]          m_tdata
);

    // A stalled result holds.
    `CCTTK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // One sample at a time: the sequencer is busy right after a transfer.
    `CCTTK_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "sample taken while busy")

    // Reset drops the output.
    `CCTTK_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind cycle_count_to_time_keeper_core ccttk_checker u_ccttk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for cycle_count_to_time_keeper_core.
// Drives counter samples and register writes, predicts every result in-bench,
// and checks each result transfer against the oldest expected time value.
`timescale 1ns / 1ps

module tb;
    import ccttk_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
    localparam int SETTLE_HOLD = 120;   // idle hold after the results drain, before a write

    // Field order matches m_tdata: ms_ticks in the lowest bits.
    typedef struct packed {
        logic [31:0] time_us;
        logic [31:0] seconds;
        logic [31:0] ms_ticks;
    } elapsed_time_t;

    typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [31:0]          value;
        bit                   known;
        elapsed_time_t        want;
    } plan_row_t;

    typedef struct {
        logic [31:0] cycles_per_ms;
        logic [31:0] cycles_per_us;
        int          idle_pct;
        int          stall_pct;
        int          items;
    } phase_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CPM_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;

    // Time keeper model state and its copy of the two registers.
    logic [CPM_W-1:0] cfg_cycles_per_ms;
    logic [CPU_W-1:0] cfg_cycles_per_us;
    bit               have_baseline;
    logic [31:0]      last_reading;
    logic [SUM_W-1:0] leftover_cycles;
    logic [31:0]      ms_total;
    logic [31:0]      sec_boundary_ms;
    logic [31:0]      sec_total;

    elapsed_time_t pending_times[$];
    plan_row_t     plan[$];
    phase_t        phases[8];

    logic [31:0] counter_now;
    int          idle_pct;
    int          stall_pct;
    int          mismatch_count;
    int          samples_sent;
    int          results_checked;
    int          quiet_cycles;

    cycle_count_to_time_keeper_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),      // [31:0] counter_value
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)       // [31:0] ms_ticks, [63:32] seconds, [95:64] time_us
    );

    always #2 aclk = ~aclk;

    // Advance the time state by one accepted counter reading; return the result it shows.
    function automatic elapsed_time_t advance_time(input logic [31:0] reading);
        logic [31:0]   delta;
        logic [31:0]   since_mark;
        logic [63:0]   divisor;
        logic [63:0]   cycles;
        logic [63:0]   extra_us;
        elapsed_time_t t;
        if (!have_baseline) begin
            // Baseline reading: record it, count nothing.
            have_baseline = 1'b1;
            last_reading  = reading;
        end else begin
            delta           = reading - last_reading;   // wraps modulo 2^32
            divisor         = (cfg_cycles_per_ms == '0) ? 64'd1 : 64'(cfg_cycles_per_ms);
            cycles          = 64'(leftover_cycles) + 64'(delta);
            ms_total        = ms_total + 32'(cycles / divisor);
            leftover_cycles = SUM_W'(cycles % divisor);
            last_reading    = reading;
        end
        // Carry whole seconds out of the millisecond count.
        since_mark      = ms_total - sec_boundary_ms;
        sec_boundary_ms = ms_total - (since_mark % 32'(MS_PER_SECOND));
        sec_total       = sec_total + since_mark / 32'(MS_PER_SECOND);
        extra_us = (cfg_cycles_per_us == '0) ? 64'd0
                 : 64'(leftover_cycles) / 64'(cfg_cycles_per_us);
        t.ms_ticks = ms_total;
        t.seconds  = sec_total;
        t.time_us  = 32'(64'(ms_total) * 64'(US_PER_MS) + extra_us);
        return t;
    endfunction

    function automatic void plan_sample(input logic [31:0] value);
        plan_row_t r;
        r.kind = ROW_SAMPLE; r.reg_index = REG_CLOCKS_PER_MS; r.value = value;
        r.known = 1'b0; r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_known(input logic [31:0] value, input logic [31:0] ms,
                                       input logic [31:0] sec, input logic [31:0] us);
        plan_row_t r;
        r.kind = ROW_SAMPLE; r.reg_index = REG_CLOCKS_PER_MS; r.value = value;
        r.known = 1'b1; r.want = '{ms_ticks: ms, seconds: sec, time_us: us};
        plan.push_back(r);
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        plan_row_t r;
        r.kind = ROW_WRITE; r.reg_index = idx; r.value = value; r.known = 1'b0; r.want = '0;
        plan.push_back(r);
    endfunction

    // Pick the next counter reading: mostly a plausible forward step, some noise.
    function automatic logic [31:0] next_reading();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = (cfg_cycles_per_ms == '0) ? 1000 : cfg_cycles_per_ms * 3;
        if (pick < 50)
            return counter_now + $urandom_range(span, 0);
        else if (pick < 65)
            return counter_now + cfg_cycles_per_ms * $urandom_range(1000, 1);
        else if (pick < 80)
            return counter_now + $urandom_range(255, 0);
        else if (pick < 95)
            return $urandom();
        else
            return counter_now - $urandom_range(16, 1);   // step back: near-full wrap
    endfunction

    // Offer one reading on the input channel; entered and left at a falling edge.
    task automatic send_reading(input logic [31:0] value, input bit known,
                                input elapsed_time_t want);
        elapsed_time_t t;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        t = advance_time(value);
        pending_times.push_back(known ? want : t);
        counter_now = value;
        samples_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid, wait for every pending result, then hold a while.
    task automatic wait_results_done(input int hold);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_times.size() != 0);
        repeat (hold) @(negedge aclk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CPM_W'(value);
        if (idx == REG_CLOCKS_PER_MS)
            cfg_cycles_per_ms = CPM_W'(value);
        else
            cfg_cycles_per_us = CPU_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Receiver: stall at the phase's rate, decided at each falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker: compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin
        elapsed_time_t want;
        elapsed_time_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_times.size() == 0) begin
                if (mismatch_count < 10)
                    $display("[%0t] unexpected result: ms=%0d sec=%0d us=%0d",
                             $realtime, got.ms_ticks, got.seconds, got.time_us);
                mismatch_count++;
            end else begin
                want = pending_times.pop_front();
                results_checked++;
                if (got.ms_ticks !== want.ms_ticks || got.seconds !== want.seconds ||
                    got.time_us !== want.time_us) begin
                    if (mismatch_count < 10)
                        $display("[%0t] result %0d: ms %0d/%0d sec %0d/%0d us %0d/%0d (exp/got)",
                                 $realtime, results_checked, want.ms_ticks, got.ms_ticks,
                                 want.seconds, got.seconds, want.time_us, got.time_us);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, pending_times.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int failures;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_CLOCKS_PER_MS;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        counter_now  = '0;
        mismatch_count = 0; samples_sent = 0; results_checked = 0; quiet_cycles = 0;

        // Model state after reset: default registers, everything else cleared.
        cfg_cycles_per_ms = CPM_RESET;
        cfg_cycles_per_us = CPU_RESET;
        have_baseline = 1'b0; last_reading = '0; leftover_cycles = '0;
        ms_total = '0; sec_boundary_ms = '0; sec_total = '0;

        // Directed part. Baseline first, then one ms, then a full second at reset settings.
        plan_known(32'hFFFF_FFF0, 32'd0, 32'd0, 32'd0);
        plan_known(32'd99984, 32'd1, 32'd0, 32'd1000);         // wraps through zero
        plan_known(32'd99999984, 32'd1000, 32'd1, 32'd1000000);
        plan_sample(32'd99999984);                             // zero difference
        plan_sample(32'd99999983);                             // difference of 2^32-1
        plan_write(REG_CLOCKS_PER_MS, 32'd1);                  // smallest legal ms period
        plan_write(REG_CLOCKS_PER_US, 32'd0);                  // microsecond part off
        plan_sample(32'd100012328);
        plan_sample(32'd0);
        plan_write(REG_CLOCKS_PER_MS, 32'd4294967);            // largest legal ms period
        plan_write(REG_CLOCKS_PER_US, 32'd4294);
        plan_sample(32'd4294966);
        plan_sample(32'd4294967);
        plan_write(REG_CLOCKS_PER_MS, 32'h007F_FFFF);          // full field width
        plan_write(REG_CLOCKS_PER_US, 32'h007F_FFFF);          // bits above 13 dropped
        plan_sample(32'd4294966);
        plan_sample(32'd12683572);
        plan_write(REG_CLOCKS_PER_MS, 32'd0);                  // zero period: one cycle per ms
        plan_write(REG_CLOCKS_PER_US, 32'd1);
        plan_sample(32'd12683571);                             // ms and us wrap
        plan_sample(32'd12683570);
        plan_write(REG_CLOCKS_PER_MS, 32'd100000);
        plan_write(REG_CLOCKS_PER_US, 32'd100);
        plan_sample(32'h0000_0000);
        plan_sample(32'hFFFF_FFFF);

        // Random phases: settings across the range, idling patterns in turn.
        phases[0] = '{32'd100000,  32'd100,  0,  0,  180};
        phases[1] = '{32'd1,       32'd0,    65, 0,  180};
        phases[2] = '{32'd4294967, 32'd4294, 0,  65, 180};
        phases[3] = '{32'h7FFFFF,  32'h1FFF, 26, 26, 180};
        phases[4] = '{32'd0,       32'd1,    0,  0,  180};
        phases[5] = '{$urandom_range(4294967, 1), $urandom_range(4294, 0), 65, 0, 180};
        phases[6] = '{32'd1000,    32'd7,    0,  65, 180};
        phases[7] = '{$urandom_range(4294967, 1), $urandom_range(4294, 0), 26, 26, 180};

        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table; let the block go idle before each write.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_results_done(SETTLE_HOLD);
                write_setting(plan[i].reg_index, plan[i].value);
            end else begin
                send_reading(plan[i].value, plan[i].known, plan[i].want);
            end
        end

        foreach (phases[p]) begin
            wait_results_done(SETTLE_HOLD);
            idle_pct  = phases[p].idle_pct;
            stall_pct = phases[p].stall_pct;
            write_setting(REG_CLOCKS_PER_MS, phases[p].cycles_per_ms);
            // Random upper data bits check that the us register ignores them.
            write_setting(REG_CLOCKS_PER_US,
                          {19'($urandom_range(1023, 0)), phases[p].cycles_per_us[CPU_W-1:0]});
            for (int n = 0; n < phases[p].items; n++) begin
                // Halfway through, hold the sender off until the pipe is empty.
                if (n == phases[p].items / 2)
                    wait_results_done(0);
                send_reading(next_reading(), 1'b0, '0);
            end
        end

        wait_results_done(200);

        $display("Ran %0d counter samples: a directed table, then %0d random phases; %0d checked.",
                 samples_sent, $size(phases), results_checked);
        $display("Periods from zero to full scale, us part on and off, with idle and stall.");
        failures = mismatch_count + pending_times.size();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
